### rtl/core/audio_level_bar_meter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the audio level bar meter
// ----------------------------------------------------------------------------
`ifndef AUDIO_LEVEL_BAR_METER_DEFINES_SVH
`define AUDIO_LEVEL_BAR_METER_DEFINES_SVH

// Implication in the same cycle, off while reset is high
`define ALBM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("albm check failed");

// Implication into the next cycle, off while reset is high
`define ALBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("albm check failed");

// Implication into the next cycle, live through reset
`define ALBM_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("albm reset check failed");

`endif

### rtl/core/albm_pkg.sv
// ----------------------------------------------------------------------------
// albm_pkg
// Shared widths, constants and the segment fraction function of the meter.
// ----------------------------------------------------------------------------
package albm_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int SENS_W          = 8;
  localparam int SEG_W           = 8;
  localparam int SEG_COUNT       = 4;
  localparam int LEVEL_W         = 23;   // Q.8 level, max 100*255*256
  localparam int PART_W          = 13;   // remainder inside one segment
  localparam int SCALE_SHIFT     = 5;    // 32768 / 1024 of the Q.8 scale
  localparam int WINDOW_DEFAULT  = 1024;
  localparam int SUM_QUEUE_DEPTH = 2;

  localparam logic [SENS_W-1:0] SENS_RESET = 8'd15;
  localparam logic [PART_W-1:0] SEG_STEP   = 13'd6400;   // 25.0 in Q.8
  localparam logic [SEG_W-1:0]  SEG_FULL   = 8'd255;

  // floor(part * 255 / 6400) for part < 6400; /256 is a shift, /25 is a
  // reciprocal multiply that stays exact below 6375.
  function automatic logic [SEG_W-1:0] seg_frac(input logic [PART_W-1:0] part);
    logic [20:0] scaled;
    logic [12:0] q256;
    logic [25:0] prod;
    scaled = (21'(part) << 8) - 21'(part);
    q256   = scaled[20:8];
    prod   = 26'(q256) * 26'd5243;
    return prod[24:17];
  endfunction

endpackage

### rtl/core/albm_front.sv
// ----------------------------------------------------------------------------
// albm_front
// Takes samples, sums their magnitudes and queues each finished window sum.
// ----------------------------------------------------------------------------
module albm_front
  import albm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEFAULT,
  parameter int SUM_W  = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       sum_push,
  output logic [SUM_W-1:0]           sum_data,
  input  logic                       sum_full
);

  localparam int CNT_W = $clog2(WINDOW);

  logic [CNT_W-1:0] sample_count;
  logic [SUM_W-1:0] abs_sum;
  logic [SAMPLE_W:0] mag;
  logic [SUM_W-1:0] sum_next;
  logic              accept;
  logic              last;

  // Sign-extend then negate: the most negative sample gives 32768
  assign mag      = sample[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {sample[SAMPLE_W-1], sample})
                                       : {1'b0, sample};
  assign sum_next = abs_sum + SUM_W'(mag);
  assign full     = sum_full;
  assign accept   = push && !sum_full;
  assign last     = (sample_count == CNT_W'(WINDOW - 1));
  assign sum_push = accept && last;
  assign sum_data = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      abs_sum      <= '0;
    end else if (accept) begin
      if (last) begin
        sample_count <= '0;
        abs_sum      <= '0;
      end else begin
        sample_count <= sample_count + 1'b1;
        abs_sum      <= sum_next;
      end
    end
  end

endmodule

### rtl/core/albm_fifo.sv
// ----------------------------------------------------------------------------
// albm_fifo
// Short queue of window sums between the accumulator and the level unit.
// ----------------------------------------------------------------------------
module albm_fifo
  import albm_pkg::*;
#(
  parameter int WIDTH = 32,
  parameter int DEPTH = SUM_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == (PTR_W+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/albm_back.sv
// ----------------------------------------------------------------------------
// albm_back
// Scales a window sum to the Q.8 level with a constant reciprocal multiply
// and splits the level into four bar segments held in an output register.
// ----------------------------------------------------------------------------
module albm_back
  import albm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEFAULT,
  parameter int SUM_W  = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SENS_W-1:0] cfg_wdata,
  input  logic              sum_empty,
  input  logic [SUM_W-1:0]  sum_data,
  output logic              sum_pop,
  output logic              empty,
  input  logic              pop,
  output logic [SEG_W-1:0]  segment_zero,
  output logic [SEG_W-1:0]  segment_one,
  output logic [SEG_W-1:0]  segment_two,
  output logic [SEG_W-1:0]  segment_three
);

  // Index of the lowest set bit, to split the power of two off WINDOW
  function automatic int low_zeros(input int v);
    int n;
    n = 0;
    while (n < 30 && v[n] == 1'b0) begin
      n++;
    end
    return n;
  endfunction

  localparam int PROD_W    = SUM_W + SENS_W;
  localparam int WIN_TZ    = low_zeros(WINDOW);
  localparam int WIN_ODD   = WINDOW >> WIN_TZ;
  localparam int ODD_L     = $clog2(WIN_ODD);
  localparam int DIV_SHIFT = WIN_TZ + SCALE_SHIFT;
  localparam int Y_W       = ODD_L + LEVEL_W;
  localparam int RECIP_SH  = Y_W + ODD_L;
  localparam int RECIP_W   = Y_W + 1;
  localparam int DIGIT_W   = 16;
  localparam int DIGITS    = (RECIP_W + DIGIT_W - 1) / DIGIT_W;
  localparam int MREM_W    = DIGITS * DIGIT_W;
  localparam int ACC_W     = Y_W + RECIP_W;
  localparam int STEP_W    = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  // ceil(2^RECIP_SH / odd part) gives an exact floor for any Y_W-bit numerator
  localparam logic [63:0] RECIP = ((64'd1 << RECIP_SH) + 64'(WIN_ODD) - 64'd1) / 64'(WIN_ODD);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_MUL,
    S_SEG,
    S_OUT
  } state_t;

  state_t              state;
  logic [SENS_W-1:0]   sensitivity;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W+4:0]   prod25;
  logic [Y_W-1:0]      num;
  logic [MREM_W-1:0]   mrem;
  logic [ACC_W-1:0]    acc;
  logic [Y_W+DIGIT_W-1:0] part_prod;
  logic [STEP_W-1:0]   step;
  logic [LEVEL_W-1:0]  level;
  logic [SEG_COUNT-1:0] seg_full;
  logic [PART_W-1:0]   seg_part [SEG_COUNT];
  logic                out_valid;
  logic                out_load;
  logic [SEG_W-1:0]    seg_val [SEG_COUNT];

  assign sum_pop   = (state == S_IDLE) && !sum_empty;
  assign out_load  = (state == S_OUT) && (!out_valid || pop);
  assign empty     = !out_valid;
  // times 25 as shift-add
  assign prod25    = ((PROD_W+5)'(prod) << 4) + ((PROD_W+5)'(prod) << 3) + (PROD_W+5)'(prod);
  assign part_prod = (Y_W+DIGIT_W)'(num) * (Y_W+DIGIT_W)'(mrem[MREM_W-1 -: DIGIT_W]);
  assign level     = acc[RECIP_SH +: LEVEL_W];

  always_comb begin
    for (int k = 0; k < SEG_COUNT; k++) begin
      seg_val[k] = seg_full[k] ? SEG_FULL : seg_frac(seg_part[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity <= SENS_RESET;
    end else if (cfg_we) begin
      sensitivity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!sum_empty) begin
            prod  <= PROD_W'(sum_data) * PROD_W'(sensitivity);
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          // drop the power of two of the divisor, leave the odd part
          num   <= Y_W'(prod25 >> DIV_SHIFT);
          mrem  <= MREM_W'(RECIP);
          acc   <= '0;
          step  <= STEP_W'(DIGITS - 1);
          state <= S_MUL;
        end
        S_MUL: begin
          // multiply by the reciprocal one digit per cycle, top digit first
          acc  <= (acc << DIGIT_W) + ACC_W'(part_prod);
          mrem <= mrem << DIGIT_W;
          if (step == '0) begin
            state <= S_SEG;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_SEG: begin
          for (int k = 0; k < SEG_COUNT; k++) begin
            logic [LEVEL_W-1:0] base;
            logic [LEVEL_W-1:0] rem;
            base = LEVEL_W'(k) * LEVEL_W'(SEG_STEP);
            rem  = level - base;
            if (level > base) begin
              seg_full[k] <= (rem >= LEVEL_W'(SEG_STEP));
              seg_part[k] <= rem[PART_W-1:0];
            end else begin
              seg_full[k] <= 1'b0;
              seg_part[k] <= '0;
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (out_load) begin
        out_valid     <= 1'b1;
        segment_zero  <= seg_val[0];
        segment_one   <= seg_val[1];
        segment_two   <= seg_val[2];
        segment_three <= seg_val[3];
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/audio_level_bar_meter.sv
// ----------------------------------------------------------------------------
// audio_level_bar_meter
// Four-segment bar meter driven by the mean magnitude of audio samples.
// ----------------------------------------------------------------------------
// Input channel: drive sample with push; it is taken on a clock edge with
// push high and full low. Samples stream in at one per cycle while full is low.
// Every WINDOW samples, the window sum goes into a two-entry queue and one
// result of four segment brightnesses follows on the output channel: it is
// shown while empty is low and leaves on an edge with pop high.
// From the edge that takes the last sample of a window, a free level unit
// does one multiply by the sensitivity, one scale by 25, two digit steps
// of the reciprocal multiply (three when the odd part of WINDOW is above
// 255), one segment split and one load of the output register, after
// which empty goes low. The level unit takes no new sum until it has loaded
// the output register, so short windows throttle input through full.
// A stalled receiver holds the result; the level unit still finishes the
// next window and the queue takes two more sums before full rises.
// cfg_we/cfg_wdata write the sensitivity; write it only while idle.
// Reset clears the window and the queue, marks the output register empty
// and sets the sensitivity to 15.
// ----------------------------------------------------------------------------
module audio_level_bar_meter
  import albm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       empty,
  input  logic                       pop,
  output logic [SEG_W-1:0]           segment_zero,
  output logic [SEG_W-1:0]           segment_one,
  output logic [SEG_W-1:0]           segment_two,
  output logic [SEG_W-1:0]           segment_three,
  input  logic                       cfg_we,
  input  logic [SENS_W-1:0]          cfg_wdata
);

  localparam int SUM_W = $clog2(longint'(WINDOW) * 32768 + 1);

  logic             sum_push;
  logic [SUM_W-1:0] sum_wdata;
  logic             sum_full;
  logic             sum_pop;
  logic [SUM_W-1:0] sum_rdata;
  logic             sum_empty;

  albm_front #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .sample   (sample),
    .sum_push (sum_push),
    .sum_data (sum_wdata),
    .sum_full (sum_full)
  );

  albm_fifo #(
    .WIDTH (SUM_W),
    .DEPTH (SUM_QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (sum_push),
    .wr_data (sum_wdata),
    .full    (sum_full),
    .rd_en   (sum_pop),
    .rd_data (sum_rdata),
    .empty   (sum_empty)
  );

  albm_back #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .sum_empty     (sum_empty),
    .sum_data      (sum_rdata),
    .sum_pop       (sum_pop),
    .empty         (empty),
    .pop           (pop),
    .segment_zero  (segment_zero),
    .segment_one   (segment_one),
    .segment_two   (segment_two),
    .segment_three (segment_three)
  );

endmodule

### rtl/core/albm_checker.sv
// ----------------------------------------------------------------------------
// albm_checker
// Port-level checks of the bar meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "audio_level_bar_meter_defines.svh"

module albm_checker
  import albm_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input logic [SEG_W-1:0] segment_zero,
  input logic [SEG_W-1:0] segment_one,
  input logic [SEG_W-1:0] segment_two,
  input logic [SEG_W-1:0] segment_three
);

  // hold a waiting result until the receiver takes it
  `ALBM_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(segment_zero) && $stable(segment_three))

  // a lit segment needs every segment below it full
  `ALBM_ASSERT_SAME(a_fill_one, !empty && segment_one != '0, segment_zero == SEG_FULL)
  `ALBM_ASSERT_SAME(a_fill_two, !empty && segment_two != '0, segment_one == SEG_FULL)
  `ALBM_ASSERT_SAME(a_fill_three, !empty && segment_three != '0, segment_two == SEG_FULL)

  // reset drops the output and opens the input
  `ALBM_ASSERT_RST(a_reset, rst, empty && !full)

endmodule

bind audio_level_bar_meter albm_checker u_albm_checker (
  .clk           (clk),
  .rst           (rst),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .segment_zero  (segment_zero),
  .segment_one   (segment_one),
  .segment_two   (segment_two),
  .segment_three (segment_three)
);
